@@ rtl/core/rhli_pkg.sv @@
// Shared constants, types and lookup tables for the RGB to hue/luma index unit.
package rhli_pkg;

  // CORDIC length; the arctangent table has 24 entries, so at most 24 steps run.
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // Field widths.
  localparam int PIXEL_W = 24;
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int LEVEL_W = 4;
  localparam int HUE_W   = 4;

  // Chroma widths: U in Q.16 fits 24 signed bits, V fits 25 signed bits.
  localparam int UW = 24;
  localparam int VW = 25;

  // CORDIC datapath widths: vector, angle accumulator, wrapped angle.
  localparam int XW      = 27;
  localparam int ZW      = 16;
  localparam int ANGLE_W = 17;

  // Luma weights; one luma level spans 16 * 1000 numerator units.
  localparam int Y_R       = 299;
  localparam int Y_G       = 587;
  localparam int Y_B       = 114;
  localparam int Y_DEN     = 1000;
  localparam int LUMA_STEP = 16000;

  // Chroma scaling: U = floor(du * 123 * 2^12 / 15625), V = floor(dv * 877 * 2^10 / 15625).
  // A bias keeps the numerator positive; it is removed again after the division.
  localparam int DIVISOR  = 15625;
  localparam int U_GAIN   = 123;
  localparam int V_GAIN   = 877;
  localparam int U_BIAS   = 32000000;   // 15625 * 2048
  localparam int V_BIAS   = 256000000;  // 15625 * 16384
  localparam int U_RECIP  = 17592186;   // floor(2^38 / 15625)
  localparam int V_RECIP  = 35184372;   // floor(2^39 / 15625)
  localparam int U_SHIFT  = 26;
  localparam int V_SHIFT  = 29;
  localparam int PU_W     = 26;
  localparam int PV_W     = 29;

  // Angles in 1/256 degree.
  localparam logic signed [ANGLE_W:0] HALF_TURN = 18'sd46080;
  localparam logic signed [ANGLE_W:0] FULL_TURN = 18'sd92160;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SATURATION = 1'b0,
    REG_THRESHOLD  = 1'b1
  } rhli_reg_e;

  // Sideband that travels with each pixel through the CORDIC pipeline.
  typedef struct packed {
    logic               colored;
    logic [LEVEL_W-1:0] level;
  } rhli_side_t;

  // atan(2^-i) in 1/256 degree, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 16'sd11520;
      1:       val = 16'sd6801;
      2:       val = 16'sd3593;
      3:       val = 16'sd1824;
      4:       val = 16'sd916;
      5:       val = 16'sd458;
      6:       val = 16'sd229;
      7:       val = 16'sd115;
      8:       val = 16'sd57;
      9:       val = 16'sd29;
      10:      val = 16'sd14;
      11:      val = 16'sd7;
      12:      val = 16'sd4;
      13:      val = 16'sd2;
      14:      val = 16'sd1;
      default: val = 16'sd0;
    endcase
    return val;
  endfunction

  // Nearest hue table entry by linear distance. The bounds are the midpoints
  // between neighboring table angles; on a midpoint the lower index wins.
  function automatic logic [HUE_W-1:0] hue_select(input logic [ANGLE_W-1:0] a);
    logic [HUE_W-1:0] hue;
    if (a < 17'd8640) begin
      hue = 4'd6;
    end else if (a < 17'd14400) begin
      hue = 4'd5;
    end else if (a < 17'd20160) begin
      hue = 4'd4;
    end else if (a < 17'd25920) begin
      hue = 4'd3;
    end else if (a < 17'd31680) begin
      hue = 4'd2;
    end else if (a <= 17'd37440) begin
      hue = 4'd1;
    end else if (a < 17'd43200) begin
      hue = 4'd14;
    end else if (a < 17'd48960) begin
      hue = 4'd13;
    end else if (a < 17'd54720) begin
      hue = 4'd12;
    end else if (a < 17'd63360) begin
      hue = 4'd11;
    end else if (a < 17'd72000) begin
      hue = 4'd10;
    end else if (a < 17'd77760) begin
      hue = 4'd9;
    end else if (a < 17'd83520) begin
      hue = 4'd8;
    end else begin
      hue = 4'd7;
    end
    return hue;
  endfunction

endpackage

@@ rtl/core/rhli_cordic.sv @@
// Pipelined vectoring CORDIC: angle of (U, V) in [0, 360) degrees, one stage per step.
module rhli_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [rhli_pkg::UW-1:0]        u_i,
  input  logic signed [rhli_pkg::VW-1:0]        v_i,
  input  rhli_pkg::rhli_side_t                  side_i,
  output logic                                  valid_o,
  output logic [rhli_pkg::ANGLE_W-1:0]          angle_o,
  output rhli_pkg::rhli_side_t                  side_o
);

  localparam int N       = rhli_pkg::CORDIC_RUN;
  localparam int XW      = rhli_pkg::XW;
  localparam int ZW      = rhli_pkg::ZW;
  localparam int UW      = rhli_pkg::UW;
  localparam int VW      = rhli_pkg::VW;
  localparam int ANGLE_W = rhli_pkg::ANGLE_W;

  // Stage 0 holds the pre-rotated vector, stage i+1 the vector after step i.
  logic                        vld_q  [0:N];
  logic signed [XW-1:0]        x_q    [0:N];
  logic signed [XW-1:0]        y_q    [0:N];
  logic signed [ZW-1:0]        z_q    [0:N];
  logic                        base_q [0:N];
  rhli_pkg::rhli_side_t        side_q [0:N];

  logic signed [XW-1:0] x_d;
  logic signed [XW-1:0] y_d;
  logic                 base_d;
  logic signed [XW-1:0] u_ext;
  logic signed [XW-1:0] v_ext;

  // Left half plane: turn the vector by 180 degrees and remember it.
  always_comb begin
    u_ext = {{(XW-UW){u_i[UW-1]}}, u_i};
    v_ext = {{(XW-VW){v_i[VW-1]}}, v_i};
    if (u_i[UW-1]) begin
      x_d    = -u_ext;
      y_d    = -v_ext;
      base_d = 1'b1;
    end else begin
      x_d    = u_ext;
      y_d    = v_ext;
      base_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_d;
      y_q[0]    <= y_d;
      z_q[0]    <= '0;
      base_q[0] <= base_d;
      side_q[0] <= side_i;
    end
  end

  // One micro-rotation per stage, driving y toward zero.
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = rhli_pkg::atan_entry(i);

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] xn_d;
    logic signed [XW-1:0] yn_d;
    logic signed [ZW-1:0] zn_d;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_comb begin
      if (!y_q[i][XW-1]) begin
        xn_d = x_q[i] + ys;
        yn_d = y_q[i] - xs;
        zn_d = z_q[i] + ATAN_I;
      end else begin
        xn_d = x_q[i] - ys;
        yn_d = y_q[i] + xs;
        zn_d = z_q[i] - ATAN_I;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= xn_d;
        y_q[i+1]    <= yn_d;
        z_q[i+1]    <= zn_d;
        base_q[i+1] <= base_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Add the half turn where the vector was flipped and wrap into [0, 360).
  logic signed [ANGLE_W:0]  zsum;
  logic signed [ANGLE_W:0]  zwrap;
  logic [ANGLE_W-1:0]       angle_d;
  logic                     valid_q;
  logic [ANGLE_W-1:0]       angle_q;
  rhli_pkg::rhli_side_t     side_w_q;

  always_comb begin
    zsum = {{(ANGLE_W+1-ZW){z_q[N][ZW-1]}}, z_q[N]};
    if (base_q[N]) begin
      zsum = zsum + rhli_pkg::HALF_TURN;
    end
    if (zsum[ANGLE_W]) begin
      zwrap = zsum + rhli_pkg::FULL_TURN;
    end else begin
      zwrap = zsum;
    end
    angle_d = zwrap[ANGLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q  <= angle_d;
      side_w_q <= side_q[N];
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;
  assign side_o  = side_w_q;

endmodule

@@ rtl/core/rgb_to_hue_luma_index_unit.sv @@
// Throughput: one pixel per cycle while the skid is empty; every stage, including each CORDIC
// step, is one register. A result that waits on output stall goes to a one-entry skid, and
// input stalls only once that skid is full.
// Reset: clears all valid bits and the skid, saturation to 0.5 and threshold to 6554/65536.
module rgb_to_hue_luma_index_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [rhli_pkg::CFG_W-1:0]     cfg_data_i,
  // Pixel input channel
  input  logic                           pixel_valid_i,
  output logic                           pixel_stall_o,
  input  logic [rhli_pkg::PIXEL_W-1:0]   pixel_rgb_i,
  // Color code output channel
  output logic                           code_valid_o,
  input  logic                           code_stall_i,
  output logic [rhli_pkg::CODE_W-1:0]    color_code_o
);

  localparam int UW      = rhli_pkg::UW;
  localparam int VW      = rhli_pkg::VW;
  localparam int LEVEL_W = rhli_pkg::LEVEL_W;
  localparam int HUE_W   = rhli_pkg::HUE_W;
  localparam int CODE_W  = rhli_pkg::CODE_W;
  localparam int CFG_W   = rhli_pkg::CFG_W;
  localparam int PU_W    = rhli_pkg::PU_W;
  localparam int PV_W    = rhli_pkg::PV_W;
  localparam int QU_W    = 24;
  localparam int QV_W    = 25;
  localparam int SQ_W    = 47;

  // ---------------------------------------------------------------------------
  // Configuration registers and the threshold square, recomputed continuously.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] sat_q;
  logic [CFG_W-1:0] thr_q;
  logic [31:0]      tp_q;
  logic [39:0]      tp255;
  logic [23:0]      tt_q;
  logic [47:0]      t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 16'd32768;
      thr_q <= 16'd6554;
    end else if (cfg_we_i) begin
      unique case (rhli_pkg::rhli_reg_e'(cfg_idx_i))
        rhli_pkg::REG_SATURATION: sat_q <= cfg_data_i;
        rhli_pkg::REG_THRESHOLD:  thr_q <= cfg_data_i;
      endcase
    end
  end

  assign tp255 = 40'(tp_q) * 40'd255;

  always_ff @(posedge clk_i) begin
    tp_q <= 32'(sat_q) * 32'(thr_q);
    tt_q <= tp255[39:16];
    t2_q <= 48'(tt_q) * 48'(tt_q);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages move together unless the skid is occupied.
  // ---------------------------------------------------------------------------
  logic       en;
  logic       skid_valid_q;
  logic [5:0] vld_q;

  assign en            = !skid_valid_q;
  assign pixel_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], pixel_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: luma numerator and the two chroma differences.
  // ---------------------------------------------------------------------------
  logic [7:0]         r_in;
  logic [7:0]         g_in;
  logic [7:0]         b_in;
  logic [17:0]        ynum_d;
  logic [17:0]        b1000;
  logic [17:0]        r1000;
  logic signed [18:0] du_d;
  logic signed [18:0] dv_d;
  logic [17:0]        ynum_a_q;
  logic signed [18:0] du_a_q;
  logic signed [18:0] dv_a_q;

  always_comb begin
    r_in   = pixel_rgb_i[23:16];
    g_in   = pixel_rgb_i[15:8];
    b_in   = pixel_rgb_i[7:0];
    ynum_d = 18'(r_in) * 18'(rhli_pkg::Y_R) + 18'(g_in) * 18'(rhli_pkg::Y_G)
           + 18'(b_in) * 18'(rhli_pkg::Y_B);
    b1000  = 18'(b_in) * 18'(rhli_pkg::Y_DEN);
    r1000  = 18'(r_in) * 18'(rhli_pkg::Y_DEN);
    du_d   = $signed({1'b0, b1000}) - $signed({1'b0, ynum_d});
    dv_d   = $signed({1'b0, r1000}) - $signed({1'b0, ynum_d});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ynum_a_q <= ynum_d;
      du_a_q   <= du_d;
      dv_a_q   <= dv_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: luma level and the biased, scaled chroma numerators.
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] level_d;
  logic signed [26:0] nu;
  logic signed [29:0] nv;
  logic [PU_W-1:0]    pu_d;
  logic [PV_W-1:0]    pv_d;
  logic [LEVEL_W-1:0] level_b_q;
  logic [PU_W-1:0]    pu_b_q;
  logic [PV_W-1:0]    pv_b_q;

  always_comb begin
    level_d = '0;
    for (int k = 1; k < (1 << LEVEL_W); k++) begin
      if (ynum_a_q >= 18'(k * rhli_pkg::LUMA_STEP)) begin
        level_d = LEVEL_W'(k);
      end
    end
    nu   = $signed({{8{du_a_q[18]}}, du_a_q}) * $signed(27'(rhli_pkg::U_GAIN))
         + $signed(27'(rhli_pkg::U_BIAS));
    nv   = $signed({{11{dv_a_q[18]}}, dv_a_q}) * $signed(30'(rhli_pkg::V_GAIN))
         + $signed(30'(rhli_pkg::V_BIAS));
    pu_d = nu[PU_W-1:0];
    pv_d = nv[PV_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_b_q <= level_d;
      pu_b_q    <= pu_d;
      pv_b_q    <= pv_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: quotient estimate by reciprocal multiply, low by at most one.
  // ---------------------------------------------------------------------------
  logic [50:0]        prod_u;
  logic [54:0]        prod_v;
  logic [LEVEL_W-1:0] level_c_q;
  logic [PU_W-1:0]    pu_c_q;
  logic [PV_W-1:0]    pv_c_q;
  logic [QU_W-1:0]    qu_c_q;
  logic [QV_W-1:0]    qv_c_q;

  assign prod_u = 51'(pu_b_q) * 51'(rhli_pkg::U_RECIP);
  assign prod_v = 55'(pv_b_q) * 55'(rhli_pkg::V_RECIP);

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_c_q <= level_b_q;
      pu_c_q    <= pu_b_q;
      pv_c_q    <= pv_b_q;
      qu_c_q    <= prod_u[rhli_pkg::U_SHIFT +: QU_W];
      qv_c_q    <= prod_v[rhli_pkg::V_SHIFT +: QV_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: remainder check corrects the quotient, then the bias is removed.
  // The remainder stays below twice the divisor, so 16 bits of it suffice.
  // ---------------------------------------------------------------------------
  logic [15:0]          rem_u;
  logic [15:0]          rem_v;
  logic [QU_W-1:0]      su;
  logic [QV_W-1:0]      sv;
  logic signed [UW-1:0] u_d;
  logic signed [VW-1:0] v_d;
  logic [LEVEL_W-1:0]   level_d_q;
  logic signed [UW-1:0] u_d_q;
  logic signed [VW-1:0] v_d_q;

  always_comb begin
    rem_u = {pu_c_q[3:0], 12'b0} - 16'(qu_c_q) * 16'(rhli_pkg::DIVISOR);
    rem_v = {pv_c_q[5:0], 10'b0} - 16'(qv_c_q) * 16'(rhli_pkg::DIVISOR);
    su    = qu_c_q + QU_W'(rem_u >= 16'(rhli_pkg::DIVISOR));
    sv    = qv_c_q + QV_W'(rem_v >= 16'(rhli_pkg::DIVISOR));
    // Subtracting 2^23 (U) or 2^24 (V) flips the top bit.
    u_d   = $signed({~su[QU_W-1], su[QU_W-2:0]});
    v_d   = $signed({~sv[QV_W-1], sv[QV_W-2:0]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_d_q <= level_c_q;
      u_d_q     <= u_d;
      v_d_q     <= v_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: squares of the chroma components.
  // ---------------------------------------------------------------------------
  logic signed [47:0]   uu_full;
  logic signed [49:0]   vv_full;
  logic [LEVEL_W-1:0]   level_e_q;
  logic signed [UW-1:0] u_e_q;
  logic signed [VW-1:0] v_e_q;
  logic [SQ_W-1:0]      uu_e_q;
  logic [SQ_W-1:0]      vv_e_q;

  assign uu_full = u_d_q * u_d_q;
  assign vv_full = v_d_q * v_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_e_q <= level_d_q;
      u_e_q     <= u_d_q;
      v_e_q     <= v_d_q;
      uu_e_q    <= uu_full[SQ_W-1:0];
      vv_e_q    <= vv_full[SQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: gray test against the squared threshold.
  // ---------------------------------------------------------------------------
  logic [47:0]           mag;
  rhli_pkg::rhli_side_t  side_d;
  rhli_pkg::rhli_side_t  side_f_q;
  logic signed [UW-1:0]  u_f_q;
  logic signed [VW-1:0]  v_f_q;

  always_comb begin
    mag            = {1'b0, uu_e_q} + {1'b0, vv_e_q};
    side_d.colored = mag > t2_q;
    side_d.level   = level_e_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_f_q <= side_d;
      u_f_q    <= u_e_q;
      v_f_q    <= v_e_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Hue angle.
  // ---------------------------------------------------------------------------
  logic                              cord_valid;
  logic [rhli_pkg::ANGLE_W-1:0]      cord_angle;
  rhli_pkg::rhli_side_t              cord_side;

  rhli_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[5]),
    .u_i     (u_f_q),
    .v_i     (v_f_q),
    .side_i  (side_f_q),
    .valid_o (cord_valid),
    .angle_o (cord_angle),
    .side_o  (cord_side)
  );

  // ---------------------------------------------------------------------------
  // Output register with one skid entry behind it.
  // ---------------------------------------------------------------------------
  logic [HUE_W-1:0]  hue;
  logic [CODE_W-1:0] code_new;
  logic              push;
  logic              take;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              skid_valid_d;
  logic              out_load;
  logic              skid_load;
  logic              skid_pop;
  logic [CODE_W-1:0] out_q;
  logic [CODE_W-1:0] skid_q;

  always_comb begin
    hue      = cord_side.colored ? rhli_pkg::hue_select(cord_angle) : '0;
    code_new = {hue, cord_side.level};
    push     = en && cord_valid;
    take     = out_valid_q && !code_stall_i;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    skid_pop     = 1'b0;
    if (skid_valid_q) begin
      if (take) begin
        skid_pop     = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_pop) begin
      out_q <= skid_q;
    end else if (out_load) begin
      out_q <= code_new;
    end
    if (skid_load) begin
      skid_q <= code_new;
    end
  end

  assign code_valid_o = out_valid_q;
  assign color_code_o = out_q;

endmodule

@@ tb/rgb_to_hue_luma_index_unit_tb.sv @@
// Self-checking testbench for the RGB to hue/luma color code unit.
module rgb_to_hue_luma_index_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  // Margin waited past the pipeline at the end of the run.
  localparam int DRAIN_CYCLES = 60;
  localparam int ROT_STEPS    = (rhli_pkg::CORDIC_STEPS < 24) ? rhli_pkg::CORDIC_STEPS : 24;

  // Arctangent of 2^-i in 1/256 degree, rounded to nearest.
  localparam longint ATAN_STEP[24] = '{
    11520, 6801, 3593, 1824, 916, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  // Hue table angles in 1/256 degree; entry 0 marks a gray pixel.
  localparam longint HUE_ANGLE[16] = '{
    0, 34560, 28800, 23040, 17280, 11520, 5760, 86400,
    80640, 74880, 69120, 57600, 51840, 46080, 40320, 34560
  };

  // Primaries, grays, faint chroma, the 135 degree tie and the wrap near 360 degrees.
  localparam logic [23:0] DIRECTED_PIXELS[20] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F,
    24'h010101, 24'hFF8000, 24'h0D0000, 24'h00000D, 24'h141010,
    24'h800000, 24'h008000, 24'h000080, 24'h55AAFF, 24'hC03060
  };

  typedef struct {
    logic [rhli_pkg::PIXEL_W-1:0] pixel;
    logic [rhli_pkg::CODE_W-1:0]  code;
  } code_entry_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [0:0]                     cfg_idx_i     = rhli_pkg::REG_SATURATION;
  logic [rhli_pkg::CFG_W-1:0]     cfg_data_i    = '0;
  logic                           pixel_valid_i = 1'b0;
  logic                           pixel_stall_o;
  logic [rhli_pkg::PIXEL_W-1:0]   pixel_rgb_i   = '0;
  logic                           code_valid_o;
  logic                           code_stall_i  = 1'b0;
  logic [rhli_pkg::CODE_W-1:0]    color_code_o;

  logic [rhli_pkg::PIXEL_W-1:0]   pending_pixels[$];
  code_entry_t                    expected_codes[$];
  code_entry_t                    new_entry;
  code_entry_t                    oldest_entry;
  logic [rhli_pkg::CFG_W-1:0]     saturation_shadow = 16'd32768;
  logic [rhli_pkg::CFG_W-1:0]     threshold_shadow  = 16'd6554;
  bit                             idle_on = 1'b1;
  int                             src_gap = 0;
  int                             sink_gap = 0;
  int                             err_count = 0;
  int                             cycle_count = 0;

  rgb_to_hue_luma_index_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_rgb_i   (pixel_rgb_i),
    .code_valid_o  (code_valid_o),
    .code_stall_i  (code_stall_i),
    .color_code_o  (color_code_o)
  );

  // Division that rounds toward minus infinity for a positive divisor.
  function automatic longint floor_quot(input longint n, input longint d);
    if (n >= 0) begin
      return n / d;
    end
    return -((-n + d - 1) / d);
  endfunction

  // Color code of one pixel under the given saturation and threshold.
  function automatic logic [rhli_pkg::CODE_W-1:0] predict_color_code(
      input logic [rhli_pkg::PIXEL_W-1:0] px,
      input logic [rhli_pkg::CFG_W-1:0]   sat,
      input logic [rhli_pkg::CFG_W-1:0]   thr);
    longint                       r, g, b, ysum, u, v, x, y, z, xs, ys, diff, best;
    longint unsigned              chroma_sq, gray_lim;
    logic [rhli_pkg::HUE_W-1:0]   hue;
    logic [rhli_pkg::LEVEL_W-1:0] level;
    r     = longint'(px[23:16]);
    g     = longint'(px[15:8]);
    b     = longint'(px[7:0]);
    ysum  = 299 * r + 587 * g + 114 * b;
    level = rhli_pkg::LEVEL_W'((ysum / 1000) >> 4);
    u     = floor_quot((1000 * b - ysum) * 492 * 65536, 1000000);
    v     = floor_quot((1000 * r - ysum) * 877 * 65536, 1000000);
    chroma_sq = longint'(u * u + v * v);
    gray_lim  = (longint'(thr) * longint'(sat) * 255) >> 16;
    hue = '0;
    if (chroma_sq > gray_lim * gray_lim) begin
      // Rotate into the right half plane, then run the vectoring CORDIC.
      x = u;
      y = v;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 46080;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP[i];
        end
      end
      while (z < 0) z = z + 92160;
      while (z >= 92160) z = z - 92160;
      // Nearest table entry; a tie keeps the lower index.
      best = 2 * 92160;
      for (int k = 1; k < 16; k++) begin
        diff = HUE_ANGLE[k] - z;
        if (diff < 0) diff = -diff;
        if (diff < best) begin
          best = diff;
          hue  = rhli_pkg::HUE_W'(k);
        end
      end
    end
    return {hue, level};
  endfunction

  task automatic report_code_error(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    err_count++;
  endtask

  // Register write at one clock edge; only called while the unit is idle.
  task automatic write_reg(input rhli_pkg::rhli_reg_e idx,
                           input logic [rhli_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == rhli_pkg::REG_SATURATION) begin
      saturation_shadow = val;
    end else begin
      threshold_shadow = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of uniform colors, near-gray pixels around the threshold, and vivid ones.
  task automatic queue_random_pixels(input int count);
    int          mode, base, ch;
    logic [23:0] px;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        px = 24'($urandom());
      end else if (mode < 8) begin
        base = $urandom_range(0, 255);
        for (int c = 0; c < 3; c++) begin
          ch = base + $urandom_range(0, 40) - 20;
          if (ch < 0) ch = 0;
          if (ch > 255) ch = 255;
          px[c*8 +: 8] = 8'(ch);
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          px[c*8 +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(192, 255))
                                               : 8'($urandom_range(0, 63));
        end
      end
      pending_pixels.push_back(px);
    end
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || pixel_valid_i || expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Free-running clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sequence of configuration phases, each followed by a full drain.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: directed pixels, then random ones.
    foreach (DIRECTED_PIXELS[i]) pending_pixels.push_back(DIRECTED_PIXELS[i]);
    queue_random_pixels(100);
    wait_idle();

    // Largest threshold: every pixel is gray.
    write_reg(rhli_pkg::REG_SATURATION, 16'hFFFF);
    write_reg(rhli_pkg::REG_THRESHOLD, 16'hFFFF);
    foreach (DIRECTED_PIXELS[i]) pending_pixels.push_back(DIRECTED_PIXELS[i]);
    queue_random_pixels(80);
    wait_idle();

    // Zero threshold: any chroma at all counts as colored.
    write_reg(rhli_pkg::REG_SATURATION, 16'h0000);
    write_reg(rhli_pkg::REG_THRESHOLD, 16'h0000);
    queue_random_pixels(120);
    wait_idle();

    write_reg(rhli_pkg::REG_SATURATION, 16'hFFFF);
    write_reg(rhli_pkg::REG_THRESHOLD, 16'd3000);
    queue_random_pixels(120);
    wait_idle();

    write_reg(rhli_pkg::REG_THRESHOLD, 16'($urandom_range(0, 20000)));
    write_reg(rhli_pkg::REG_SATURATION, 16'($urandom()));
    queue_random_pixels(120);
    wait_idle();

    // Last stretch runs at full rate on both sides.
    write_reg(rhli_pkg::REG_SATURATION, 16'd40000);
    write_reg(rhli_pkg::REG_THRESHOLD, 16'd9000);
    idle_on = 1'b0;
    queue_random_pixels(150);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("rgb_to_hue_luma_index_unit_tb passed");
    end else begin
      $display("rgb_to_hue_luma_index_unit_tb failed");
    end
    $finish;
  end

  // Pixel driver: records the expected code on each transfer and presents the next pixel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_valid_i && !pixel_stall_o) begin
        new_entry.pixel = pixel_rgb_i;
        new_entry.code  = predict_color_code(pixel_rgb_i, saturation_shadow, threshold_shadow);
        expected_codes.push_back(new_entry);
        void'(pending_pixels.pop_front());
        if (idle_on && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 3);
        end
      end
      if (pixel_valid_i && pixel_stall_o) begin
        // Stalled: hold the payload as it is.
      end else if (src_gap > 0) begin
        src_gap--;
        pixel_valid_i <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        pixel_valid_i <= 1'b1;
        pixel_rgb_i   <= pending_pixels[0];
      end else begin
        pixel_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (code_valid_o && !code_stall_i) begin
        if (expected_codes.size() == 0) begin
          report_code_error($sformatf("unexpected color code %02h", color_code_o));
        end else begin
          oldest_entry = expected_codes.pop_front();
          if (color_code_o !== oldest_entry.code) begin
            report_code_error($sformatf("pixel %06h: color code %02h, expected %02h",
                                        oldest_entry.pixel, color_code_o, oldest_entry.code));
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        code_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 2);
        code_stall_i <= 1'b1;
      end else begin
        code_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: ERROR timeout", $time);
      $display("rgb_to_hue_luma_index_unit_tb failed");
      $finish;
    end
  end

endmodule
